>>> design/mtk_pkg.sv
// ----------------------------------------------------------------------------
// mtk_pkg
// types, codes and the character lists of the multi-tap keypad text entry
// ----------------------------------------------------------------------------
package mtk_pkg;

  localparam int CountWidth = 16;
  localparam int QueueDepth = 4;
  localparam int PtrWidth   = $clog2(QueueDepth);
  localparam logic [15:0] TimeoutReset = 16'd1000;

  typedef enum logic [1:0] {
    OpKey  = 2'd0,
    OpTick = 2'd1,
    OpMode = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ModeUpper  = 2'd0,
    ModeLower  = 2'd1,
    ModeDigits = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    KindStatus = 2'd0,
    KindAppend = 2'd1,
    KindDelete = 2'd2
  } kind_e;

  localparam logic [7:0] KeyA     = 8'h41;
  localparam logic [7:0] KeyB     = 8'h42;
  localparam logic [7:0] KeyD     = 8'h44;
  localparam logic [7:0] KeyStar  = 8'h2A;
  localparam logic [7:0] KeyZero  = 8'h30;
  localparam logic [7:0] KeyNine  = 8'h39;
  localparam logic [7:0] KeySpace = 8'h20;
  localparam logic [7:0] UpperA   = 8'h41;
  localparam logic [7:0] UpperZ   = 8'h5A;
  localparam logic [7:0] CaseGap  = 8'd32;

  // work of one input item, handed from the front to the back
  typedef struct packed {
    logic [1:0] n_ev;
    kind_e      ev0_kind;
    logic [7:0] ev0_char;
    kind_e      ev1_kind;
    logic [7:0] ev1_char;
    logic [7:0] pending_char;
    mode_e      mode;
    logic       handled;
  } plan_t;

  function automatic logic [3:0] list_len(input logic [3:0] digit);
    logic [3:0] len;
    unique case (digit)
      4'd0:    len = 4'd2;
      4'd1:    len = 4'd9;
      4'd7:    len = 4'd5;
      4'd9:    len = 4'd5;
      4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd8: len = 4'd4;
      default: len = 4'd1;
    endcase
    return len;
  endfunction

  // lists are right-justified, first character in the highest used byte
  function automatic logic [71:0] list_row(input logic [3:0] digit);
    logic [71:0] row;
    unique case (digit)
      4'd0:    row = 72'(" 0");
      4'd1:    row = 72'(".,?!@-_/1");
      4'd2:    row = 72'("ABC2");
      4'd3:    row = 72'("DEF3");
      4'd4:    row = 72'("GHI4");
      4'd5:    row = 72'("JKL5");
      4'd6:    row = 72'("MNO6");
      4'd7:    row = 72'("PQRS7");
      4'd8:    row = 72'("TUV8");
      4'd9:    row = 72'("WXYZ9");
      default: row = '0;
    endcase
    return row;
  endfunction

  function automatic logic [7:0] list_char(input logic [3:0] digit,
                                           input logic [3:0] pos,
                                           input logic       lower);
    logic [3:0]  len;
    logic [3:0]  p;
    logic [3:0]  idx;
    logic [71:0] row;
    logic [7:0]  c;
    len = list_len(digit);
    row = list_row(digit);
    p   = (pos >= len) ? 4'd0 : pos;
    idx = 4'(len - p - 4'd1);
    c   = row[{idx, 3'b000} +: 8];
    if (lower && c >= UpperA && c <= UpperZ) begin
      c = 8'(c + CaseGap);
    end
    return c;
  endfunction

endpackage

>>> design/mtk_if.sv
// ----------------------------------------------------------------------------
// mtk_in_if / mtk_out_if
// valid-ready channels for keypad items and for result words
// ----------------------------------------------------------------------------
interface mtk_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] key;
  logic [1:0] new_mode;

  modport source (output valid, output op, output key, output new_mode, input ready);
  modport sink   (input valid, input op, input key, input new_mode, output ready);
endinterface

interface mtk_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_char;
  logic       pending_valid;
  logic [7:0] pending_char;
  logic [1:0] cur_mode;
  logic       handled;
  logic       last_of_run;

  modport source (output valid, output kind, output out_char, output pending_valid,
                  output pending_char, output cur_mode, output handled,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_char, input pending_valid,
                  input pending_char, input cur_mode, input handled,
                  input last_of_run, output ready);
endinterface

>>> design/mtk_front.sv
// ----------------------------------------------------------------------------
// mtk_front
// accepts keypad items, keeps the entry state and builds one plan per item
// ----------------------------------------------------------------------------
module mtk_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mtk_in_if.sink               in_i,
  input  logic [15:0]          timeout_i,
  output logic                 push_valid_o,
  output mtk_pkg::plan_t       push_plan_o,
  input  logic                 push_ready_i
);

  logic [7:0]                      pending_q, pending_d;
  logic [7:0]                      prev_q, prev_d;
  logic [3:0]                      cyc_q, cyc_d;
  logic [15:0]                     elapsed_q, elapsed_d;
  mtk_pkg::mode_e                  mode_q, mode_d;
  logic [mtk_pkg::CountWidth-1:0]  count_q, count_d, count_1;

  logic           pend, is_digit, cycling, do_commit, c_ev;
  logic           x_ev;
  mtk_pkg::kind_e x_kind;
  logic [7:0]     x_char;
  logic           handled;
  logic [15:0]    elapsed_inc;
  logic [3:0]     digit, pos_inc, pos;
  logic           fire;

  assign fire         = in_i.valid && push_ready_i;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  assign pend        = pending_q != 8'd0;
  assign digit       = in_i.key[3:0];
  assign is_digit    = in_i.key >= mtk_pkg::KeyZero && in_i.key <= mtk_pkg::KeyNine;
  assign cycling     = in_i.key == prev_q && elapsed_q < timeout_i && pend;
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : 16'(elapsed_q + 16'd1);
  assign pos_inc     = 4'(cyc_q + 4'd1);

  always_comb begin
    do_commit = 1'b0;
    unique case (in_i.op)
      mtk_pkg::OpKey: begin
        do_commit = in_i.key == mtk_pkg::KeyD || in_i.key == mtk_pkg::KeyB ||
                    in_i.key == mtk_pkg::KeyA ||
                    (is_digit && (mode_q == mtk_pkg::ModeDigits || !cycling));
      end
      mtk_pkg::OpTick: do_commit = elapsed_inc >= timeout_i;
      mtk_pkg::OpMode: do_commit = 1'b1;
      default:         do_commit = 1'b0;
    endcase
  end

  assign c_ev = do_commit && pend;

  always_comb begin
    pending_d = c_ev ? 8'd0 : pending_q;
    prev_d    = c_ev ? 8'd0 : prev_q;
    cyc_d     = c_ev ? 4'd0 : cyc_q;
    elapsed_d = elapsed_q;
    mode_d    = mode_q;
    x_ev      = 1'b0;
    x_kind    = mtk_pkg::KindAppend;
    x_char    = 8'd0;
    handled   = 1'b0;
    pos       = 4'd0;
    unique case (in_i.op)
      mtk_pkg::OpKey: begin
        priority if (in_i.key == mtk_pkg::KeyD) begin
          handled = 1'b1;
          unique case (mode_q)
            mtk_pkg::ModeUpper: mode_d = mtk_pkg::ModeLower;
            mtk_pkg::ModeLower: mode_d = mtk_pkg::ModeDigits;
            default:            mode_d = mtk_pkg::ModeUpper;
          endcase
        end else if (in_i.key == mtk_pkg::KeyStar) begin
          handled = 1'b1;
          if (pend) begin
            pending_d = 8'd0;
            prev_d    = 8'd0;
            cyc_d     = 4'd0;
          end else if (count_q != '0) begin
            x_ev   = 1'b1;
            x_kind = mtk_pkg::KindDelete;
          end
        end else if (in_i.key == mtk_pkg::KeyB) begin
          handled = 1'b1;
          x_ev    = 1'b1;
          x_char  = mtk_pkg::KeySpace;
        end else if (in_i.key == mtk_pkg::KeyA) begin
          handled = 1'b1;
        end else if (is_digit) begin
          handled = 1'b1;
          if (mode_q == mtk_pkg::ModeDigits) begin
            x_ev   = 1'b1;
            x_char = in_i.key;
          end else begin
            if (cycling) begin
              pos = (pos_inc >= mtk_pkg::list_len(digit)) ? 4'd0 : pos_inc;
            end else begin
              prev_d = in_i.key;
            end
            cyc_d     = pos;
            pending_d = mtk_pkg::list_char(digit, pos, mode_q == mtk_pkg::ModeLower);
            elapsed_d = 16'd0;
          end
        end else begin
          handled = 1'b0;
        end
      end
      mtk_pkg::OpTick: begin
        handled   = 1'b1;
        elapsed_d = elapsed_inc;
      end
      mtk_pkg::OpMode: begin
        handled = 1'b1;
        mode_d  = (in_i.new_mode == mtk_pkg::ModeUpper) ? mtk_pkg::ModeUpper :
                  (in_i.new_mode == mtk_pkg::ModeLower) ? mtk_pkg::ModeLower :
                  mtk_pkg::ModeDigits;
      end
      default: handled = 1'b0;
    endcase
  end

  // saturating count, commit first and then the extra word
  always_comb begin
    count_1 = (c_ev && count_q != '1) ? count_q + 1'b1 : count_q;
    count_d = count_1;
    if (x_ev && x_kind == mtk_pkg::KindAppend && count_1 != '1) begin
      count_d = count_1 + 1'b1;
    end else if (x_ev && x_kind == mtk_pkg::KindDelete) begin
      count_d = count_1 - 1'b1;
    end
  end

  always_comb begin
    push_plan_o.n_ev         = 2'({1'b0, c_ev} + {1'b0, x_ev});
    push_plan_o.ev0_kind     = c_ev ? mtk_pkg::KindAppend : x_kind;
    push_plan_o.ev0_char     = c_ev ? pending_q : x_char;
    push_plan_o.ev1_kind     = x_kind;
    push_plan_o.ev1_char     = x_char;
    push_plan_o.pending_char = pending_d;
    push_plan_o.mode         = mode_d;
    push_plan_o.handled      = handled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 8'd0;
      prev_q    <= 8'd0;
      cyc_q     <= 4'd0;
      elapsed_q <= 16'd0;
      mode_q    <= mtk_pkg::ModeLower;
      count_q   <= '0;
    end else if (fire) begin
      pending_q <= pending_d;
      prev_q    <= prev_d;
      cyc_q     <= cyc_d;
      elapsed_q <= elapsed_d;
      mode_q    <= mode_d;
      count_q   <= count_d;
    end
  end

endmodule

>>> design/mtk_fifo.sv
// ----------------------------------------------------------------------------
// mtk_fifo
// short plan queue between the front and the back
// ----------------------------------------------------------------------------
module mtk_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  input  mtk_pkg::plan_t      push_plan_i,
  output logic                push_ready_o,
  output logic                pop_valid_o,
  output mtk_pkg::plan_t      pop_plan_o,
  input  logic                pop_ready_i
);

  mtk_pkg::plan_t                mem_q [mtk_pkg::QueueDepth];
  logic [mtk_pkg::PtrWidth-1:0]  wr_q, rd_q;
  logic [mtk_pkg::PtrWidth:0]    cnt_q;
  logic                          push, pop;

  assign push_ready_o = cnt_q != (mtk_pkg::PtrWidth+1)'(mtk_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_plan_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> design/mtk_back.sv
// ----------------------------------------------------------------------------
// mtk_back
// plays one plan out as event words followed by a status word
// ----------------------------------------------------------------------------
module mtk_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  input  mtk_pkg::plan_t      pop_plan_i,
  output logic                pop_ready_o,
  mtk_out_if.source           out_o
);

  logic           cur_q;
  mtk_pkg::plan_t plan_q;
  logic [1:0]     idx_q;
  logic           last, fire;

  assign last        = idx_q == plan_q.n_ev;
  assign fire        = out_o.valid && out_o.ready;
  assign pop_ready_o = !cur_q || (fire && last);

  always_comb begin
    out_o.valid         = cur_q;
    out_o.last_of_run   = last;
    out_o.pending_valid = plan_q.pending_char != 8'd0;
    out_o.pending_char  = plan_q.pending_char;
    out_o.cur_mode      = plan_q.mode;
    out_o.handled       = plan_q.handled;
    if (last) begin
      out_o.kind     = mtk_pkg::KindStatus;
      out_o.out_char = 8'd0;
    end else if (idx_q == 2'd0) begin
      out_o.kind     = plan_q.ev0_kind;
      out_o.out_char = plan_q.ev0_char;
    end else begin
      out_o.kind     = plan_q.ev1_kind;
      out_o.out_char = plan_q.ev1_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      plan_q <= pop_plan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (pop_ready_o) begin
      cur_q <= pop_valid_i;
      idx_q <= 2'd0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

>>> design/multitap_keypad_text_entry.sv
// ----------------------------------------------------------------------------
// multitap_keypad_text_entry
// multi-tap keypad text entry with append and delete words for outside text
//
//   channel  dir  handshake        word
//   in_i     in   valid/ready      op, key, new_mode
//   out_o    out  valid/ready      kind, out_char, status fields, last_of_run
//   apb      in   psel/penable     timeout_ms at every address (paddr is ignored)
//
// the front takes one item per cycle while the 4-entry plan queue has room
// each item leaves as k+1 words (k = 0..2 events), one word per cycle while out_o.ready is high
// rst_ni clears all state, sets lowercase mode and timeout 1000
// an output stall fills the queue, then holds in_i.ready low
// ----------------------------------------------------------------------------
module multitap_keypad_text_entry (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtk_in_if.sink      in_i,
  mtk_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0]    timeout_q;
  logic           push_valid, push_ready, pop_valid, pop_ready;
  mtk_pkg::plan_t push_plan, pop_plan;

  assign pready = 1'b1;
  assign prdata = {16'd0, timeout_q};

  // single register, all address bits are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= mtk_pkg::TimeoutReset;
    end else if (psel && penable && pwrite && pready) begin
      timeout_q <= pwdata[15:0];
    end
  end

  mtk_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .timeout_i    (timeout_q),
    .push_valid_o (push_valid),
    .push_plan_o  (push_plan),
    .push_ready_i (push_ready)
  );

  mtk_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_plan_i  (push_plan),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_plan_o   (pop_plan),
    .pop_ready_i  (pop_ready)
  );

  mtk_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_plan_i  (pop_plan),
    .pop_ready_o (pop_ready),
    .out_o       (out_o)
  );

  a_event_not_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.last_of_run |-> out_o.kind != mtk_pkg::KindStatus)
    else $error("event word carries status kind");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.last_of_run |-> out_o.kind == mtk_pkg::KindStatus &&
                                          out_o.out_char == 8'd0)
    else $error("status word carries an event");

  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.ready && !out_o.last_of_run |=> out_o.valid)
    else $error("run broken before its status word");

  a_pending_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.pending_valid == (out_o.pending_char != 8'd0))
    else $error("pending flag disagrees with pending character");

endmodule
